// File: design/hmas_pkg.sv
// ---------------------------------------------------------------------------
// hmas_pkg
// Shared types and constants of the heightmap altitude sampler: register
// codes, reset values, and the words passed between the pipeline parts.
// ---------------------------------------------------------------------------
package hmas_pkg;

	// default grid edge length
	localparam int MAP_SIZE_DEF = 256;

	// result queue depth, also the credit limit on queries in flight
	localparam int OUTQ_DEPTH = 8;

	// register reset values
	localparam logic [31:0] X_TO_GRID_RST   = 32'h00FF_0000;
	localparam logic [31:0] Z_TO_GRID_RST   = 32'h00FF_0000;
	localparam logic [31:0] HEIGHT_GAIN_RST = 32'd257;
	localparam logic [7:0]  MAP_LAST_RST    = 8'd255;

	// one in Q0.16, and the largest positive altitude
	localparam logic [16:0] ONE_Q16 = 17'h1_0000;
	localparam logic [31:0] ALT_MAX = 32'h7FFF_FFFF;

	// input word actions
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// register index codes
	typedef enum logic [1:0] {
		REG_X_TO_GRID   = 2'd0,
		REG_Z_TO_GRID   = 2'd1,
		REG_HEIGHT_GAIN = 2'd2,
		REG_MAP_LAST    = 2'd3
	} hmas_reg_t;

	// accepted input word
	typedef struct packed {
		logic        action;
		logic [7:0]  cell_x;
		logic [7:0]  cell_z;
		logic [7:0]  sample;
		logic [31:0] point_x;
		logic [31:0] point_z;
		logic [31:0] point_y;
	} hmas_item_t;

	// memory access request from the grid mapping stages
	typedef struct packed {
		logic        valid;
		logic        load;
		logic [7:0]  cell_x;
		logic [7:0]  cell_z;
		logic [7:0]  sample;
		logic        outside;
		logic [7:0]  cx;
		logic [7:0]  cz;
		logic [15:0] fx;
		logic [15:0] fz;
		logic [31:0] py;
	} hmas_access_t;

	// query context aligned with the memory read data
	typedef struct packed {
		logic        valid;
		logic        outside;
		logic [15:0] fx;
		logic [15:0] fz;
		logic [31:0] py;
	} hmas_tap_t;

	// the four corner samples of a cell
	typedef struct packed {
		logic [7:0] h00;
		logic [7:0] h10;
		logic [7:0] h01;
		logic [7:0] h11;
	} hmas_corners_t;

	// result word
	typedef struct packed {
		logic [31:0] altitude;
		logic        under_ground;
		logic        outside;
	} hmas_result_t;

endpackage

// File: design/hmas_req_if.sv
// ---------------------------------------------------------------------------
// hmas_req_if
// Input channel: load or query words with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface hmas_req_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic [7:0]         cell_x;
	logic [7:0]         cell_z;
	logic [7:0]         sample;
	logic signed [31:0] point_x;
	logic signed [31:0] point_z;
	logic signed [31:0] point_y;

	modport source (
		output valid, action, cell_x, cell_z, sample, point_x, point_z, point_y,
		input  ready
	);

	modport sink (
		input  valid, action, cell_x, cell_z, sample, point_x, point_z, point_y,
		output ready
	);
endinterface

// File: design/hmas_rsp_if.sv
// ---------------------------------------------------------------------------
// hmas_rsp_if
// Result channel: altitude words with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface hmas_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] altitude;
	logic               under_ground;
	logic               outside;

	modport source (
		output valid, altitude, under_ground, outside,
		input  ready
	);

	modport sink (
		input  valid, altitude, under_ground, outside,
		output ready
	);
endinterface

// File: design/hmas_grid.sv
// ---------------------------------------------------------------------------
// hmas_grid
// Maps the world point into grid space over three stages: input register,
// scale multiply, offset add. Splits the grid point into cell and fraction
// and flags cells outside the map.
// ---------------------------------------------------------------------------
module hmas_grid (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  hmas_pkg::hmas_item_t item,
	input  logic [31:0]          x_to_grid,
	input  logic [31:0]          z_to_grid,
	input  logic [7:0]           map_last,
	input  logic [7:0]           last_eff,
	output hmas_pkg::hmas_access_t access
);
	import hmas_pkg::*;

	logic               valid_s1, valid_s2, valid_s3;
	hmas_item_t         item_s1, item_s2, item_s3;
	logic signed [64:0] mul_x, mul_z;
	logic signed [63:0] prod_x_s2, prod_z_s2;
	logic signed [48:0] half;
	logic signed [48:0] gx_s3, gz_s3;
	logic               out_x, out_z;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// exact products of signed point and unsigned factor
	assign mul_x = 65'($signed(item_s1.point_x)) * 65'($signed({1'b0, x_to_grid}));
	assign mul_z = 65'($signed(item_s1.point_z)) * 65'($signed({1'b0, z_to_grid}));

	// half of the last index in Q16.16
	assign half = $signed({26'd0, map_last, 15'd0});

	// payload stages
	always_ff @(posedge clk) begin
		item_s1   <= item;
		item_s2   <= item_s1;
		prod_x_s2 <= mul_x[63:0];
		prod_z_s2 <= mul_z[63:0];
		item_s3   <= item_s2;
		gx_s3     <= 49'(prod_x_s2 >>> 16) + half;
		gz_s3     <= 49'(prod_z_s2 >>> 16) + half;
	end

	// cell range check: negative, far above, or at or past the last index
	assign out_x = gx_s3[48] | (|gx_s3[47:24]) | (gx_s3[23:16] >= last_eff);
	assign out_z = gz_s3[48] | (|gz_s3[47:24]) | (gz_s3[23:16] >= last_eff);

	// access word to the height store
	always_comb begin
		access.valid   = valid_s3;
		access.load    = (item_s3.action == ACT_LOAD);
		access.cell_x  = item_s3.cell_x;
		access.cell_z  = item_s3.cell_z;
		access.sample  = item_s3.sample;
		access.outside = out_x | out_z;
		access.cx      = gx_s3[23:16];
		access.cz      = gz_s3[23:16];
		access.fx      = gx_s3[15:0];
		access.fz      = gz_s3[15:0];
		access.py      = item_s3.point_y;
	end

endmodule

// File: design/hmas_store.sv
// ---------------------------------------------------------------------------
// hmas_store
// Height samples in four banks split by x and z parity, so the four corners
// of any cell sit in four different banks and are read together. Loads
// write in the same stage in which queries read, which keeps program order.
// ---------------------------------------------------------------------------
module hmas_store #(
	parameter int MAP_SIZE = hmas_pkg::MAP_SIZE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hmas_pkg::hmas_access_t access,
	output hmas_pkg::hmas_tap_t    tap,
	output hmas_pkg::hmas_corners_t corners
);
	import hmas_pkg::*;

	localparam int Span      = (MAP_SIZE < 256) ? MAP_SIZE : 256;
	localparam int HalfW     = ($clog2((Span + 1) / 2) > 0) ? $clog2((Span + 1) / 2) : 1;
	localparam int AddrW     = 2 * HalfW;
	localparam int BankDepth = 1 << AddrW;

	logic             wr_ok, wr_en;
	logic [1:0]       wr_bank;
	logic [AddrW-1:0] wr_addr;
	logic [7:0]       rdata_s4 [4];
	logic             valid_s4, outside_s4, cx_odd_s4, cz_odd_s4;
	logic [15:0]      fx_s4, fz_s4;
	logic [31:0]      py_s4;
	logic [7:0]       lo_z0, hi_z0, lo_z1, hi_z1;

	// loads outside the map are dropped
	assign wr_ok   = ({24'd0, access.cell_x} < 32'(MAP_SIZE))
		&& ({24'd0, access.cell_z} < 32'(MAP_SIZE));
	assign wr_en   = access.valid & access.load & wr_ok;
	assign wr_bank = {access.cell_z[0], access.cell_x[0]};
	assign wr_addr = {HalfW'(access.cell_z >> 1), HalfW'(access.cell_x >> 1)};

	// one bank per parity pair
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic BankX = 1'(b % 2);
		localparam logic BankZ = 1'(b / 2);

		logic [7:0]       mem [BankDepth];
		logic [7:0]       xs, zs;
		logic [AddrW-1:0] rd_addr;

		// pick the corner of this cell that falls in this bank
		always_comb begin
			xs      = (access.cx[0] == BankX) ? access.cx : 8'(access.cx + 8'd1);
			zs      = (access.cz[0] == BankZ) ? access.cz : 8'(access.cz + 8'd1);
			rd_addr = {HalfW'(zs >> 1), HalfW'(xs >> 1)};
		end

		always_ff @(posedge clk) begin
			if (wr_en && (wr_bank == 2'(b))) begin
				mem[wr_addr] <= access.sample;
			end
			rdata_s4[b] <= mem[rd_addr];
		end
	end

	// query context alongside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= access.valid & ~access.load;
		end
	end

	always_ff @(posedge clk) begin
		outside_s4 <= access.outside;
		cx_odd_s4  <= access.cx[0];
		cz_odd_s4  <= access.cz[0];
		fx_s4      <= access.fx;
		fz_s4      <= access.fz;
		py_s4      <= access.py;
	end

	// undo the parity swap: first across x, then across z
	always_comb begin
		lo_z0 = cx_odd_s4 ? rdata_s4[1] : rdata_s4[0];
		hi_z0 = cx_odd_s4 ? rdata_s4[0] : rdata_s4[1];
		lo_z1 = cx_odd_s4 ? rdata_s4[3] : rdata_s4[2];
		hi_z1 = cx_odd_s4 ? rdata_s4[2] : rdata_s4[3];
		corners.h00 = cz_odd_s4 ? lo_z1 : lo_z0;
		corners.h10 = cz_odd_s4 ? hi_z1 : hi_z0;
		corners.h01 = cz_odd_s4 ? lo_z0 : lo_z1;
		corners.h11 = cz_odd_s4 ? hi_z0 : hi_z1;
	end

	always_comb begin
		tap.valid   = valid_s4;
		tap.outside = outside_s4;
		tap.fx      = fx_s4;
		tap.fz      = fz_s4;
		tap.py      = py_s4;
	end

endmodule

// File: design/hmas_blend.sv
// ---------------------------------------------------------------------------
// hmas_blend
// Barycentric weighting of three corner samples, height gain multiply,
// saturation and the below-ground compare.
// ---------------------------------------------------------------------------
module hmas_blend (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hmas_pkg::hmas_tap_t     tap,
	input  hmas_pkg::hmas_corners_t corners,
	input  logic [31:0]             height_gain,
	output logic                    push,
	output hmas_pkg::hmas_result_t  res
);
	import hmas_pkg::*;

	logic [16:0] fsum, wa, wb, wc;
	logic        lower;
	logic [7:0]  ha, hb;
	logic [24:0] pa, pb, pc, sum_full;
	logic [23:0] sum_s5;
	logic [55:0] scale;
	logic [55:0] scale_s6;
	logic [39:0] scaled;
	logic [31:0] alt;
	logic        valid_s5, valid_s6, outside_s5, outside_s6;
	logic [31:0] py_s5, py_s6;

	// triangle choice and weights in Q0.16
	always_comb begin
		fsum  = {1'b0, tap.fx} + {1'b0, tap.fz};
		lower = (fsum <= ONE_Q16);
		wa    = lower ? (ONE_Q16 - fsum) : (ONE_Q16 - {1'b0, tap.fz});
		wb    = lower ? {1'b0, tap.fx} : (fsum - ONE_Q16);
		wc    = lower ? {1'b0, tap.fz} : (ONE_Q16 - {1'b0, tap.fx});
		ha    = lower ? corners.h00 : corners.h10;
		hb    = lower ? corners.h10 : corners.h11;
	end

	// weighted sum, at most 255 * 2^16
	always_comb begin
		pa       = 25'(wa) * 25'(ha);
		pb       = 25'(wb) * 25'(hb);
		pc       = 25'(wc) * 25'(corners.h01);
		sum_full = pa + pb + pc;
	end

	assign scale = 56'(sum_s5) * 56'(height_gain);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s5 <= tap.valid;
			valid_s6 <= valid_s5;
		end
	end

	// outside cells give a zero sum and so a zero altitude
	always_ff @(posedge clk) begin
		sum_s5     <= tap.outside ? '0 : sum_full[23:0];
		outside_s5 <= tap.outside;
		py_s5      <= tap.py;
		scale_s6   <= scale;
		outside_s6 <= outside_s5;
		py_s6      <= py_s5;
	end

	// drop the fraction and saturate to the positive range
	always_comb begin
		scaled = scale_s6[55:16];
		alt    = (|scaled[39:31]) ? ALT_MAX : scaled[31:0];
	end

	always_comb begin
		push             = valid_s6;
		res.altitude     = alt;
		res.under_ground = ($signed(py_s6) < $signed(alt));
		res.outside      = outside_s6;
	end

endmodule

// File: design/hmas_outq.sv
// ---------------------------------------------------------------------------
// hmas_outq
// Result queue that parts the free-running pipeline from the result
// channel. Admission credits upstream keep it from overflowing.
// ---------------------------------------------------------------------------
module hmas_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  hmas_pkg::hmas_result_t res,
	hmas_rsp_if.source             rsp
);
	import hmas_pkg::*;

	localparam int PtrW = ($clog2(OUTQ_DEPTH) > 0) ? $clog2(OUTQ_DEPTH) : 1;
	localparam int CntW = $clog2(OUTQ_DEPTH + 1);

	hmas_result_t    q_mem [OUTQ_DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            pop;
	hmas_result_t    head;

	assign pop = rsp.valid & rsp.ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= res;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + CntW'(1);
				2'b01: count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// head word to the channel
	assign head             = q_mem[rd_ptr_q];
	assign rsp.valid        = (count_q != '0);
	assign rsp.altitude     = $signed(head.altitude);
	assign rsp.under_ground = head.under_ground;
	assign rsp.outside      = head.outside;

endmodule

// File: design/heightmap_altitude_sampler.sv
// ---------------------------------------------------------------------------
// heightmap_altitude_sampler
// Top level: configuration registers, admission credits, and the
// grid / store / blend / result queue pipeline.
// ---------------------------------------------------------------------------
// The block takes one word per clock, load or query, while a credit is free,
// and answers each query with one result word; loads give no result. Words
// pass in order through three grid mapping stages, one stage at the height
// store, and two blend stages, then wait in an 8-entry result queue.
// Queries in flight are counted, and the input is held off only while eight
// are outstanding, so a stalled result channel stops intake once eight
// queries sit in the pipeline or the queue. The store is four parity banks
// with one read and one write port each, which serve the four corners of a
// cell together; loads write in the same stage in which queries read, so a
// query sees every load accepted before it. The store is not cleared at
// reset: each sample a query touches must be loaded first. Registers must be
// written only while no query is in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
module heightmap_altitude_sampler #(
	parameter int MAP_SIZE = hmas_pkg::MAP_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	hmas_req_if.sink            req,
	hmas_rsp_if.source          rsp,
	input  logic                cfg_we,
	input  hmas_pkg::hmas_reg_t cfg_idx,
	input  logic [31:0]         cfg_wdata
);
	import hmas_pkg::*;

	localparam int CntW    = $clog2(OUTQ_DEPTH + 1);
	localparam int LastMax = (MAP_SIZE - 1 < 255) ? MAP_SIZE - 1 : 255;

	logic [31:0]     x_to_grid_q, z_to_grid_q, height_gain_q;
	logic [7:0]      map_last_q, last_eff;
	logic [CntW-1:0] outstanding_q;
	logic            accept, rsp_take;
	hmas_item_t      item;
	hmas_access_t    access;
	hmas_tap_t       tap;
	hmas_corners_t   corners;
	logic            push;
	hmas_result_t    res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_to_grid_q   <= X_TO_GRID_RST;
			z_to_grid_q   <= Z_TO_GRID_RST;
			height_gain_q <= HEIGHT_GAIN_RST;
			map_last_q    <= MAP_LAST_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_X_TO_GRID:   x_to_grid_q   <= cfg_wdata;
				REG_Z_TO_GRID:   z_to_grid_q   <= cfg_wdata;
				REG_HEIGHT_GAIN: height_gain_q <= cfg_wdata;
				REG_MAP_LAST:    map_last_q    <= cfg_wdata[7:0];
			endcase
		end
	end

	// last index limited to the map
	assign last_eff = (map_last_q > 8'(LastMax)) ? 8'(LastMax) : map_last_q;

	// admission credits: queries in the pipeline plus those queued
	assign req.ready = (outstanding_q < CntW'(OUTQ_DEPTH));
	assign accept    = req.valid & req.ready;
	assign rsp_take  = rsp.valid & rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			unique case ({accept && (req.action == ACT_QUERY), rsp_take})
				2'b10: outstanding_q <= outstanding_q + CntW'(1);
				2'b01: outstanding_q <= outstanding_q - CntW'(1);
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	// input word
	always_comb begin
		item.action  = req.action;
		item.cell_x  = req.cell_x;
		item.cell_z  = req.cell_z;
		item.sample  = req.sample;
		item.point_x = req.point_x;
		item.point_z = req.point_z;
		item.point_y = req.point_y;
	end

	hmas_grid u_grid (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.x_to_grid (x_to_grid_q),
		.z_to_grid (z_to_grid_q),
		.map_last  (map_last_q),
		.last_eff  (last_eff),
		.access    (access)
	);

	hmas_store #(
		.MAP_SIZE (MAP_SIZE)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.access  (access),
		.tap     (tap),
		.corners (corners)
	);

	hmas_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.tap         (tap),
		.corners     (corners),
		.height_gain (height_gain_q),
		.push        (push),
		.res         (res)
	);

	hmas_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.rsp    (rsp)
	);

	// credit count never passes the queue depth
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= CntW'(OUTQ_DEPTH))
		else $error("query credit count above queue depth");

	// a queued result always holds a credit
	a_result_credit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (outstanding_q != '0))
		else $error("result offered with no query in flight");

	// points off the map read as zero altitude
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.outside) |-> (rsp.altitude == 32'sd0))
		else $error("outside result with nonzero altitude");

	// altitude is saturated to the positive range
	a_alt_positive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !rsp.altitude[31])
		else $error("negative altitude");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the heightmap altitude sampler. Load words fill
// the height store and query words ask for the altitude under a world point.
// Every accepted query is run through an in-bench predictor, and each result
// word is checked field by field against the oldest pending altitude.
// Query points are mostly aimed at cells of the current grid. Before a query
// that lands inside the grid, the four corners of its cell are loaded if they
// have not been written yet. Sender and receiver both idle at random.
// ---------------------------------------------------------------------------
module testbench;
	import hmas_pkg::*;

	localparam int EDGE_LEN     = MAP_SIZE_DEF;
	localparam int SETTLE       = 16;     // pipeline stages plus queue margin
	localparam int STALL_LIMIT  = 5000;   // cycles with no handshake before giving up
	localparam int RANDOM_ITEMS = 800;
	localparam int PHASES       = 9;
	localparam int MAX_PRINTS   = 40;
	localparam longint ONE      = 65536;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	hmas_reg_t   cfg_idx;
	logic [31:0] cfg_wdata;

	hmas_req_if req_ch ();
	hmas_rsp_if rsp_ch ();

	heightmap_altitude_sampler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// predictor copy of the registers and the height store
	logic [31:0] x_scale;
	logic [31:0] z_scale;
	logic [31:0] gain;
	logic [7:0]  last_idx;
	logic [7:0]  terrain [0:EDGE_LEN*EDGE_LEN-1];

	// entries that the stimulus has already loaded (ahead of the predictor)
	bit          loaded [0:EDGE_LEN*EDGE_LEN-1];

	hmas_item_t   words_to_send [$];
	hmas_result_t altitudes_due [$];

	int src_idle_pct;
	int snk_stall_pct;
	int planned;
	int errors;
	int n_loads;
	int n_queries;
	int n_outside;
	int n_under;
	int n_clipped;
	int n_settings;
	int quiet_cycles;

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one axis into grid space: Q32.32 product floored to Q16.16 plus half the span
	function automatic longint grid_coord(logic [31:0] p, logic [31:0] scale);
		longint pw;
		longint sw;
		pw = longint'($signed(p));
		sw = {32'd0, scale};
		return ((pw * sw) >>> 16) + longint'(last_idx) * (ONE / 2);
	endfunction

	// cell of a grid point, and whether it lies inside the used grid
	function automatic bit cell_inside(longint gx, longint gz, output longint cx,
			output longint cz);
		longint lim;
		lim = (last_idx > EDGE_LEN - 1) ? EDGE_LEN - 1 : last_idx;
		cx = gx >>> 16;
		cz = gz >>> 16;
		return cx >= 0 && cz >= 0 && cx < lim && cz < lim;
	endfunction

	// expected result word of one query
	function automatic hmas_result_t predict_altitude(hmas_item_t w);
		hmas_result_t r;
		longint gx, gz, cx, cz, fx, fz;
		longint h00, h10, h01, h11, mix, alt;
		gx = grid_coord(w.point_x, x_scale);
		gz = grid_coord(w.point_z, z_scale);
		alt = 0;
		r.outside = 1'b1;
		if (cell_inside(gx, gz, cx, cz)) begin
			r.outside = 1'b0;
			fx = gx - (cx <<< 16);
			fz = gz - (cz <<< 16);
			h00 = terrain[int'(cz * EDGE_LEN + cx)];
			h10 = terrain[int'(cz * EDGE_LEN + cx + 1)];
			h01 = terrain[int'((cz + 1) * EDGE_LEN + cx)];
			h11 = terrain[int'((cz + 1) * EDGE_LEN + cx + 1)];
			// lower triangle includes the diagonal
			if (fx + fz <= ONE)
				mix = (ONE - fx - fz) * h00 + fx * h10 + fz * h01;
			else
				mix = (ONE - fz) * h10 + (fx + fz - ONE) * h11 + (ONE - fx) * h01;
			alt = (mix * longint'({32'd0, gain})) >>> 16;
			if (alt > longint'({32'd0, ALT_MAX}))
				alt = {32'd0, ALT_MAX};
		end
		r.altitude = alt[31:0];
		r.under_ground = longint'($signed(w.point_y)) < alt;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		if (errors < MAX_PRINTS)
			$display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	// stimulus building
	task automatic plan_load(int x, int z, logic [7:0] v);
		hmas_item_t w;
		w.action  = ACT_LOAD;
		w.cell_x  = x[7:0];
		w.cell_z  = z[7:0];
		w.sample  = v;
		w.point_x = $urandom();
		w.point_z = $urandom();
		w.point_y = $urandom();
		words_to_send = {words_to_send, w};
		loaded[z * EDGE_LEN + x] = 1'b1;
		planned++;
	endtask

	function automatic logic [7:0] rand_sample();
		return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
	endfunction

	// a query word; corners that were never loaded get a load word first
	task automatic plan_query(logic [31:0] px, logic [31:0] pz, logic [31:0] py);
		hmas_item_t w;
		longint cx, cz;
		if (cell_inside(grid_coord(px, x_scale), grid_coord(pz, z_scale), cx, cz)) begin
			for (int dz = 0; dz < 2; dz++)
				for (int dx = 0; dx < 2; dx++)
					if (!loaded[int'((cz + dz) * EDGE_LEN + cx + dx)])
						plan_load(int'(cx + dx), int'(cz + dz), rand_sample());
		end
		w.action  = ACT_QUERY;
		w.cell_x  = 8'($urandom());
		w.cell_z  = 8'($urandom());
		w.sample  = 8'($urandom());
		w.point_x = px;
		w.point_z = pz;
		w.point_y = py;
		words_to_send = {words_to_send, w};
		planned++;
	endtask

	// world coordinate that lands near grid coordinate g on one axis
	function automatic logic [31:0] world_of(longint g, logic [31:0] scale);
		longint p;
		if (scale == 0)
			return $urandom();
		p = ((g - longint'(last_idx) * (ONE / 2)) <<< 16) / longint'({32'd0, scale});
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;
		return p[31:0];
	endfunction

	task automatic aim_query(longint gx, longint gz, logic [31:0] py);
		plan_query(world_of(gx, x_scale), world_of(gz, z_scale), py);
	endtask

	function automatic logic [31:0] rand_height();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 32'h0003_FFFF);
			2: return 32'h0;
			default: return $urandom_range(0, 32'h00FF_FFFF);
		endcase
	endfunction

	task automatic random_word();
		int r;
		int lim;
		r = $urandom_range(0, 99);
		lim = last_idx;
		if (r < 15) begin
			// overwrite a sample, now and then anywhere in the store
			if ($urandom_range(0, 3) == 0)
				plan_load($urandom_range(0, EDGE_LEN - 1), $urandom_range(0, EDGE_LEN - 1),
					rand_sample());
			else
				plan_load($urandom_range(0, lim), $urandom_range(0, lim), rand_sample());
		end else if (r < 30) begin
			plan_query($urandom(), $urandom(), rand_height());
		end else begin
			aim_query(longint'($urandom_range(0, (lim + 1) * ONE)) - ONE / 2,
				longint'($urandom_range(0, (lim + 1) * ONE)) - ONE / 2, rand_height());
		end
	endtask

	// register write, with the predictor copy updated alongside
	task automatic write_reg(hmas_reg_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_X_TO_GRID:   x_scale  = val;
			REG_Z_TO_GRID:   z_scale  = val;
			REG_HEIGHT_GAIN: gain     = val;
			REG_MAP_LAST:    last_idx = val[7:0];
		endcase
	endtask

	task automatic set_config(logic [31:0] xs, logic [31:0] zs, logic [31:0] g,
			logic [7:0] last);
		write_reg(REG_X_TO_GRID, xs);
		write_reg(REG_Z_TO_GRID, zs);
		write_reg(REG_HEIGHT_GAIN, g);
		write_reg(REG_MAP_LAST, {24'd0, last});
		n_settings++;
	endtask

	function automatic logic [31:0] rand_scale();
		case ($urandom_range(0, 2))
			0: return 32'h0001_0000;
			1: return $urandom_range(32'h0000_2000, 32'h0008_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 2))
			0: return 32'd257;
			1: return $urandom_range(1, 32'h0010_0000);
			default: return $urandom();
		endcase
	endfunction

	// wait until every word is sent and every result is back, then let loads settle
	task automatic wait_idle();
		while (words_to_send.size() != 0 || req_ch.valid || altitudes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// input driver
	always @(posedge clk) begin
		hmas_item_t nxt;
		logic drive;
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.action  <= ACT_LOAD;
			req_ch.cell_x  <= 8'h0;
			req_ch.cell_z  <= 8'h0;
			req_ch.sample  <= 8'h0;
			req_ch.point_x <= 32'sh0;
			req_ch.point_z <= 32'sh0;
			req_ch.point_y <= 32'sh0;
		end else if (!req_ch.valid || req_ch.ready) begin
			drive = words_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct;
			if (drive) begin
				nxt = words_to_send.pop_front();
				req_ch.action  <= nxt.action;
				req_ch.cell_x  <= nxt.cell_x;
				req_ch.cell_z  <= nxt.cell_z;
				req_ch.sample  <= nxt.sample;
				req_ch.point_x <= nxt.point_x;
				req_ch.point_z <= nxt.point_z;
				req_ch.point_y <= nxt.point_y;
			end
			req_ch.valid <= drive;
		end
	end

	// result receiver
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= $urandom_range(0, 99) >= snk_stall_pct;
	end

	// accepted input words feed the predictor
	always @(posedge clk) begin
		hmas_item_t w;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			w.action  = req_ch.action;
			w.cell_x  = req_ch.cell_x;
			w.cell_z  = req_ch.cell_z;
			w.sample  = req_ch.sample;
			w.point_x = req_ch.point_x;
			w.point_z = req_ch.point_z;
			w.point_y = req_ch.point_y;
			if (w.action == ACT_LOAD) begin
				terrain[int'(w.cell_z) * EDGE_LEN + int'(w.cell_x)] = w.sample;
				n_loads++;
			end else begin
				altitudes_due = {altitudes_due, predict_altitude(w)};
				n_queries++;
			end
		end
	end

	// result words against the oldest pending altitude
	always @(posedge clk) begin
		hmas_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (altitudes_due.size() == 0) begin
				report("unexpected result word", rsp_ch.altitude, 32'h0);
			end else begin
				want = altitudes_due.pop_front();
				if (rsp_ch.altitude !== want.altitude)
					report("altitude", rsp_ch.altitude, want.altitude);
				if (rsp_ch.under_ground !== want.under_ground)
					report("under_ground", {31'd0, rsp_ch.under_ground}, {31'd0, want.under_ground});
				if (rsp_ch.outside !== want.outside)
					report("outside", {31'd0, rsp_ch.outside}, {31'd0, want.outside});
				n_outside += want.outside;
				n_under += want.under_ground;
				n_clipped += (want.altitude == ALT_MAX);
			end
		end
	end

	// watchdog on traffic
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("no handshake for %0d cycles, %0d results pending", STALL_LIMIT,
				altitudes_due.size());
			$display("testbench NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int start;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = REG_X_TO_GRID;
		cfg_wdata      = 32'h0;
		x_scale        = X_TO_GRID_RST;
		z_scale        = Z_TO_GRID_RST;
		gain           = HEIGHT_GAIN_RST;
		last_idx       = MAP_LAST_RST;
		src_idle_pct   = 17;
		snk_stall_pct  = 86;
		planned        = 0;
		errors         = 0;
		n_loads        = 0;
		n_queries      = 0;
		n_outside      = 0;
		n_under        = 0;
		n_clipped      = 0;
		n_settings     = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: store corners, grid center, far outside, last inside cell
		plan_load(0, 0, 8'h00);
		plan_load(EDGE_LEN - 1, EDGE_LEN - 1, 8'hFF);
		plan_load(EDGE_LEN - 1, 0, 8'hFF);
		plan_load(0, EDGE_LEN - 1, 8'h00);
		plan_query(32'h0, 32'h0, 32'h0);
		plan_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		plan_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		aim_query(254 * ONE + 'hC000, 254 * ONE + 'h2000, 32'h0);
		wait_idle();

		// unit scale, small grid, full gain: exact fractions
		set_config(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF, 8'd4);
		aim_query(0, 0, 32'h8000_0000);                        // cell origin, zero fraction
		aim_query(3 * ONE + 'hFFFF, 3 * ONE + 'hFFFF, 32'h7FFF_FFFF); // upper triangle
		aim_query(ONE + 'h4000, ONE + 'hC000, 32'h0);          // on the diagonal
		aim_query(ONE + 'h4001, ONE + 'hC000, 32'h0);          // just past it
		aim_query(4 * ONE, 0, 32'h0);                          // at the last index
		aim_query(-1, 0, 32'hFFFF_FFFF);                       // just below zero
		plan_load(2, 2, 8'hFF);
		plan_load(3, 2, 8'hFF);
		plan_load(2, 3, 8'hFF);
		plan_load(3, 3, 8'hFF);
		aim_query(2 * ONE + 'h8000, 2 * ONE + 'h4000, 32'h7FFF_FFFF); // saturates
		wait_idle();

		// zero x scale, largest z scale, zero gain, one-cell grid
		set_config(32'h0, 32'hFFFF_FFFF, 32'h0, 8'd1);
		plan_query($urandom(), 32'h0, 32'h0);
		plan_query($urandom(), 32'h0, 32'hFFFF_FFFF);
		plan_query($urandom(), 32'h1, 32'h0);
		plan_query($urandom(), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_idle();

		// random phases: idling sender-light, then receiver-light, then none
		for (int ph = 0; ph < PHASES; ph++) begin
			src_idle_pct  = (ph < 3) ? 17 : (ph < 6) ? 86 : 0;
			snk_stall_pct = (ph < 3) ? 86 : (ph < 6) ? 17 : 0;
			set_config(rand_scale(), rand_scale(), rand_gain(),
				(ph == 0) ? 8'd255 : (ph == 4) ? 8'd1 :
				(ph == PHASES - 1) ? 8'($urandom_range(17, 254)) : 8'($urandom_range(2, 16)));
			start = planned;
			while (planned - start < RANDOM_ITEMS / PHASES)
				random_word();
			wait_idle();
		end

		$display("covered %0d loads and %0d queries over %0d register settings",
			n_loads, n_queries, n_settings);
		$display("results: %0d outside the grid, %0d under ground, %0d clipped",
			n_outside, n_under, n_clipped);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
